// ===== rtl/udpss_pkg.sv =====
// ----------------------------------------------------------------------------
// UDP port socket steering package
// Shared widths, protocol constants, codes and payload types of the block.
// ----------------------------------------------------------------------------
package udpss_pkg;

  localparam int SocketsPerGroupDefault = 16;
  localparam int SlotTableDepthDefault  = 1024;

  localparam int PortW     = 16;
  localparam int LenW      = 14;
  localparam int EtherW    = 16;
  localparam int ProtoW    = 8;
  localparam int QueueW    = 8;
  localparam int EntryIdxW = 10;
  localparam int CountW    = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int SlotW     = PortW + 1;
  localparam int DivW      = 16;

  localparam logic [EtherW-1:0] EthP8023Min   = 16'h0600;
  localparam logic [EtherW-1:0] EthPIp        = 16'h0800;
  localparam logic [ProtoW-1:0] IpprotoUdp    = 8'd17;
  localparam logic [LenW-1:0]   LenEth        = 14'd14;
  localparam logic [LenW-1:0]   LenEthIp      = 14'd34;
  localparam logic [LenW-1:0]   LenEthIpUdp   = 14'd42;

  localparam logic [PortW-1:0]  PortLowReset    = 16'd1024;
  localparam logic [PortW-1:0]  PortHighReset   = 16'd2047;
  localparam logic [QueueW-1:0] QueueCountReset = 8'd1;

  typedef enum logic {
    OP_STEER,
    OP_TABLE_WRITE
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_PASS,
    VERDICT_ABORTED,
    VERDICT_REDIRECT,
    VERDICT_WRITE_DONE
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PORT_RANGE_LOW,
    CFG_PORT_RANGE_HIGH,
    CFG_QUEUE_COUNT
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_BASE_START,
    S_BASE_WAIT,
    S_QUOT_START,
    S_QUOT_WAIT,
    S_IDLE,
    S_MUL,
    S_ALIGN,
    S_INDEX,
    S_READ,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e                  operation;
    logic [LenW-1:0]      frame_length;
    logic [EtherW-1:0]    ether_type;
    logic [ProtoW-1:0]    ip_protocol;
    logic [PortW-1:0]     udp_dest_port;
    logic [QueueW-1:0]    rx_queue;
    logic [EntryIdxW-1:0] entry_index;
    logic [CountW-1:0]    entry_socket_count;
  } steer_in_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [PortW-1:0] socket_slot;
  } steer_out_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [DivW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/udpss_stream_if.sv =====
// ----------------------------------------------------------------------------
// UDP port socket steering stream interface
// Valid/ready channel with a typed payload; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface udpss_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/udp_port_socket_steering_core.sv =====
// ----------------------------------------------------------------------------
// UDP port socket steering core
// Steers IPv4/UDP packets to socket slots by destination port with round-robin
// spreading over the sockets of a slot, and takes socket count table writes.
// ----------------------------------------------------------------------------
// The block works on one item at a time. A steered packet passes header check
// with the port reciprocal multiply, group alignment, table index, table read,
// counter update and output register before the next possible input transfer;
// a packet that aborts on the table bound leaves after the table index, and a
// passed packet or a table write goes from the header check straight to the
// output register. After reset, input is held off while both memories are
// cleared one entry per cycle, then while the range base is aligned by the
// reciprocal multiply and the serial divider derives the per-queue offset.
// Every configuration write repeats that alignment and divider pass before the
// next input transfer.
module udp_port_socket_steering_core #(
  parameter int SOCKETS_PER_GROUP = udpss_pkg::SocketsPerGroupDefault,
  parameter int SLOT_TABLE_DEPTH  = udpss_pkg::SlotTableDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  udpss_stream_if.sink                     in_i,
  udpss_stream_if.source                   out_o,
  input  logic                             cfg_we_i,
  input  logic [udpss_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [udpss_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int PortW   = udpss_pkg::PortW;
  localparam int QueueW  = udpss_pkg::QueueW;
  localparam int CountW  = udpss_pkg::CountW;
  localparam int SlotW   = udpss_pkg::SlotW;
  localparam int DivW    = udpss_pkg::DivW;
  localparam int IdxW    = $clog2(SLOT_TABLE_DEPTH);
  localparam int SpgW    = $clog2(SOCKETS_PER_GROUP + 1);
  localparam int RecipS  = PortW + $clog2(SOCKETS_PER_GROUP);
  localparam int RecipMW = RecipS + 1;
  localparam logic [RecipMW-1:0] RecipM =
    RecipMW'(((longint'(1) << RecipS) + SOCKETS_PER_GROUP - 1) / SOCKETS_PER_GROUP);
  localparam int ProdW   = PortW + RecipMW;
  localparam int AlignW  = PortW + SpgW;
  localparam int OffW    = SpgW + QueueW;
  localparam logic [SlotW-1:0] DepthLimit = SlotW'(SLOT_TABLE_DEPTH);
  localparam logic [IdxW-1:0]  LastAddr   = IdxW'(SLOT_TABLE_DEPTH - 1);

  function automatic logic [CountW-1:0] mod_small(input logic [CountW:0] x,
                                                  input logic [CountW-1:0] m);
    logic [CountW:0] r;
    r = '0;
    for (int i = CountW; i >= 0; i--) begin
      r = {r[CountW-1:0], x[i]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
    end
    return r[CountW-1:0];
  endfunction

  udpss_pkg::state_e     state_q, state_d;
  logic [IdxW-1:0]       clr_addr_q, clr_addr_d;
  logic                  dirty_q, dirty_d;
  logic [PortW-1:0]      port_low_q, port_low_d;
  logic [PortW-1:0]      port_high_q, port_high_d;
  logic [QueueW-1:0]     queue_count_q, queue_count_d;
  logic                  out_valid_q, out_valid_d;

  logic [PortW-1:0]      base_q;
  logic [SpgW-1:0]       quot_q;
  udpss_pkg::steer_in_t  item_q;
  logic [PortW-1:0]      pq_q;
  logic [OffW-1:0]       offset_q;
  logic [SlotW-1:0]      slot_q;
  logic [IdxW-1:0]       idx_q;
  udpss_pkg::steer_out_t res_q, res_d;
  udpss_pkg::steer_out_t out_payload_q;

  udpss_pkg::div_req_t   div_req;
  udpss_pkg::div_rsp_t   div_rsp;

  logic                  in_ready;
  logic                  in_xfer;
  logic                  res_load;
  logic                  out_load;

  logic                  cnt_we, rr_we, ram_re;
  logic [IdxW-1:0]       cnt_waddr, rr_waddr, ram_raddr;
  logic [CountW-1:0]     cnt_wdata, rr_wdata;
  logic [CountW-1:0]     cnt_rdata, rr_rdata;

  logic                  hdr_ok;
  logic                  entry_in_range;
  logic [PortW-1:0]      mul_in;
  logic [ProdW-1:0]      prod;
  logic [OffW-1:0]       offset_d;
  logic [AlignW-1:0]     aligned_full;
  logic [SlotW-1:0]      slot_d;
  logic [SlotW-1:0]      idx_full;
  logic                  in_table;
  logic                  cnt_gt1;
  logic [CountW-1:0]     rr_new;
  logic [SlotW-1:0]      slot_sum;
  logic                  slot_overflow;

  assign in_xfer = in_i.valid && in_ready;

  always_comb begin
    hdr_ok = (item_q.frame_length >= udpss_pkg::LenEth)
          && (item_q.ether_type >= udpss_pkg::EthP8023Min)
          && (item_q.ether_type == udpss_pkg::EthPIp)
          && (item_q.frame_length >= udpss_pkg::LenEthIp)
          && (item_q.ip_protocol == udpss_pkg::IpprotoUdp)
          && (item_q.frame_length >= udpss_pkg::LenEthIpUdp)
          && (item_q.udp_dest_port >= port_low_q)
          && (item_q.udp_dest_port <= port_high_q);
    entry_in_range = SlotW'(item_q.entry_index) < DepthLimit;
    mul_in   = (state_q == udpss_pkg::S_BASE_START) ? port_low_q : item_q.udp_dest_port;
    prod     = ProdW'(mul_in) * ProdW'(RecipM);
    offset_d = OffW'(quot_q) * OffW'(item_q.rx_queue);
    aligned_full = AlignW'(pq_q) * AlignW'(SOCKETS_PER_GROUP);
    slot_d   = SlotW'(aligned_full)
             + ((queue_count_q > QueueW'(1)) ? SlotW'(offset_q) : SlotW'(0));
    idx_full = slot_q - SlotW'(base_q);
    in_table = idx_full < DepthLimit;
    cnt_gt1  = cnt_rdata > CountW'(1);
    rr_new   = cnt_gt1 ? mod_small({1'b0, rr_rdata} + (CountW + 1)'(1), cnt_rdata)
                       : '0;
    slot_sum = slot_q + SlotW'(rr_new);
    slot_overflow = slot_sum[PortW];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      udpss_pkg::S_CLEAR: begin
        if (clr_addr_q == LastAddr) begin
          state_d = udpss_pkg::S_BASE_START;
        end
      end
      udpss_pkg::S_BASE_START: state_d = udpss_pkg::S_BASE_WAIT;
      udpss_pkg::S_BASE_WAIT:  state_d = udpss_pkg::S_QUOT_START;
      udpss_pkg::S_QUOT_START: state_d = udpss_pkg::S_QUOT_WAIT;
      udpss_pkg::S_QUOT_WAIT: begin
        if (div_rsp.done) begin
          state_d = udpss_pkg::S_IDLE;
        end
      end
      udpss_pkg::S_IDLE: begin
        if (dirty_q) begin
          state_d = udpss_pkg::S_BASE_START;
        end else if (in_xfer) begin
          state_d = udpss_pkg::S_MUL;
        end
      end
      udpss_pkg::S_MUL: begin
        if (item_q.operation == udpss_pkg::OP_TABLE_WRITE || !hdr_ok) begin
          state_d = udpss_pkg::S_OUT;
        end else begin
          state_d = udpss_pkg::S_ALIGN;
        end
      end
      udpss_pkg::S_ALIGN: state_d = udpss_pkg::S_INDEX;
      udpss_pkg::S_INDEX: state_d = in_table ? udpss_pkg::S_READ : udpss_pkg::S_OUT;
      udpss_pkg::S_READ:  state_d = udpss_pkg::S_OUT;
      udpss_pkg::S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = udpss_pkg::S_IDLE;
        end
      end
      default: state_d = udpss_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_load  = 1'b0;
    out_load  = 1'b0;
    res_d     = '{verdict: udpss_pkg::VERDICT_PASS, socket_slot: '0};
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr_q;
    cnt_wdata = '0;
    rr_we     = 1'b0;
    rr_waddr  = clr_addr_q;
    rr_wdata  = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_full[IdxW-1:0];
    div_req   = '{start: 1'b0, dividend: '0, divisor: '0};
    unique case (state_q)
      udpss_pkg::S_CLEAR: begin
        cnt_we = 1'b1;
        rr_we  = 1'b1;
      end
      udpss_pkg::S_QUOT_START: begin
        div_req = '{start: 1'b1, dividend: DivW'(SOCKETS_PER_GROUP),
                    divisor: DivW'(queue_count_q)};
      end
      udpss_pkg::S_IDLE: begin
        in_ready = !dirty_q && !cfg_we_i;
      end
      udpss_pkg::S_MUL: begin
        if (item_q.operation == udpss_pkg::OP_TABLE_WRITE) begin
          cnt_we    = entry_in_range;
          cnt_waddr = IdxW'(item_q.entry_index);
          cnt_wdata = item_q.entry_socket_count;
          res_load  = 1'b1;
          res_d.verdict = udpss_pkg::VERDICT_WRITE_DONE;
        end else if (!hdr_ok) begin
          res_load = 1'b1;
        end
      end
      udpss_pkg::S_INDEX: begin
        ram_re = in_table;
        if (!in_table) begin
          res_load = 1'b1;
          res_d.verdict = udpss_pkg::VERDICT_ABORTED;
        end
      end
      udpss_pkg::S_READ: begin
        rr_we    = cnt_gt1 && !slot_overflow;
        rr_waddr = idx_q;
        rr_wdata = rr_new;
        res_load = 1'b1;
        if (slot_overflow) begin
          res_d.verdict = udpss_pkg::VERDICT_ABORTED;
        end else begin
          res_d.verdict     = udpss_pkg::VERDICT_REDIRECT;
          res_d.socket_slot = slot_sum[PortW-1:0];
        end
      end
      udpss_pkg::S_OUT: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    clr_addr_d = (state_q == udpss_pkg::S_CLEAR) ? clr_addr_q + IdxW'(1) : clr_addr_q;
    if (cfg_we_i) begin
      dirty_d = 1'b1;
    end else if (state_q == udpss_pkg::S_BASE_START) begin
      dirty_d = 1'b0;
    end else begin
      dirty_d = dirty_q;
    end
    port_low_d    = port_low_q;
    port_high_d   = port_high_q;
    queue_count_d = queue_count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        udpss_pkg::CFG_PORT_RANGE_LOW:  port_low_d    = cfg_wdata_i[PortW-1:0];
        udpss_pkg::CFG_PORT_RANGE_HIGH: port_high_d   = cfg_wdata_i[PortW-1:0];
        udpss_pkg::CFG_QUEUE_COUNT:     queue_count_d = cfg_wdata_i[QueueW-1:0];
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= udpss_pkg::S_CLEAR;
      clr_addr_q    <= '0;
      dirty_q       <= 1'b1;
      port_low_q    <= udpss_pkg::PortLowReset;
      port_high_q   <= udpss_pkg::PortHighReset;
      queue_count_q <= udpss_pkg::QueueCountReset;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      dirty_q       <= dirty_d;
      port_low_q    <= port_low_d;
      port_high_q   <= port_high_d;
      queue_count_q <= queue_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_i.payload;
    end
    if (state_q == udpss_pkg::S_BASE_WAIT) begin
      base_q <= aligned_full[PortW-1:0];
    end
    if (state_q == udpss_pkg::S_QUOT_WAIT && div_rsp.done) begin
      quot_q <= SpgW'(div_rsp.quotient);
    end
    if (state_q == udpss_pkg::S_MUL || state_q == udpss_pkg::S_BASE_START) begin
      pq_q <= prod[RecipS +: PortW];
    end
    if (state_q == udpss_pkg::S_MUL) begin
      offset_q <= offset_d;
    end
    if (state_q == udpss_pkg::S_ALIGN) begin
      slot_q <= slot_d;
    end
    if (state_q == udpss_pkg::S_INDEX) begin
      idx_q <= idx_full[IdxW-1:0];
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_payload_q <= res_q;
    end
  end

  udpss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  udpss_ram #(
    .Width (CountW),
    .Depth (SLOT_TABLE_DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (cnt_rdata)
  );

  udpss_ram #(
    .Width (CountW),
    .Depth (SLOT_TABLE_DEPTH)
  ) u_rr_ram (
    .clk_i   (clk_i),
    .we_i    (rr_we),
    .waddr_i (rr_waddr),
    .wdata_i (rr_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rr_rdata)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_payload_q;

  a_rr_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rr_we && state_q == udpss_pkg::S_READ |-> rr_wdata < cnt_rdata)
    else $error("round-robin update not below the socket count");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == udpss_pkg::S_OUT))
    else $error("output became valid outside the output state");

  a_redirect_above_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_q.verdict == udpss_pkg::VERDICT_REDIRECT
      |-> res_q.socket_slot >= base_q)
    else $error("redirect slot below the aligned range base");

  a_base_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == udpss_pkg::S_IDLE && !dirty_q
      |-> {1'b0, port_low_q - base_q} < (PortW + 1)'(SOCKETS_PER_GROUP))
    else $error("range base is not within one group of the low port");

endmodule

// ===== rtl/udpss_ram.sv =====
// ----------------------------------------------------------------------------
// UDP port socket steering RAM
// Generic simple dual-port memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module udpss_ram #(
  parameter int Width = udpss_pkg::CountW,
  parameter int Depth = udpss_pkg::SlotTableDepthDefault,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/udpss_div.sv =====
// ----------------------------------------------------------------------------
// UDP port socket steering divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module udpss_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  udpss_pkg::div_req_t req_i,
  output udpss_pkg::div_rsp_t rsp_o
);

  localparam int DivW = udpss_pkg::DivW;
  localparam int CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] den_q, den_d;

  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;
  logic            fits;

  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
